// File: src/nfrs_pkg.sv
`default_nettype none

package nfrs_pkg;

   // Fixed field widths of the channels
   localparam int CoordW  = 32;
   localparam int RegionW = 4;
   localparam int SlotW   = 4;
   localparam int DistW   = CoordW + 1;

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic [DistW-1:0]         dist_type;

   // One stored rectangle, one memory word
   typedef struct packed {
      coord_type low_x;
      coord_type low_y;
      coord_type high_x;
      coord_type high_y;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: src/nfrs_ifs.sv
`default_nettype none

// Request channel: load a rectangle or query a point
interface nfrs_req_if import nfrs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [RegionW-1:0]   region_id;
   logic [SlotW-1:0]     rect_slot;
   coord_type            rect_low_x;
   coord_type            rect_low_y;
   coord_type            rect_high_x;
   coord_type            rect_high_y;
   coord_type            point_x;
   coord_type            point_y;

   modport source (
      output valid, cmd, region_id, rect_slot, rect_low_x, rect_low_y,
             rect_high_x, rect_high_y, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, cmd, region_id, rect_slot, rect_low_x, rect_low_y,
             rect_high_x, rect_high_y, point_x, point_y,
      output ready
   );
endinterface

// Response channel: nearest point of the chosen rectangle
interface nfrs_rsp_if import nfrs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   coord_type            nearest_x;
   coord_type            nearest_y;
   logic [SlotW-1:0]     best_rect;
   dist_type             distance;
   logic                 empty_region;

   modport source (
      output valid, nearest_x, nearest_y, best_rect, distance, empty_region,
      input  ready
   );
   modport sink (
      input  valid, nearest_x, nearest_y, best_rect, distance, empty_region,
      output ready
   );
endinterface

`default_nettype wire

// File: src/nearest_fence_rect_search.sv
`default_nettype none
//  channel   | dir | handshake          | beat carries
//  req_bus   | in  | valid / ready      | cmd, region_id, rect_slot, rect corners, point
//  rsp_bus   | out | valid / ready      | nearest_x/y, best_rect, distance, empty_region
//
//  A load leaves the request side open. A query holds the request side
//  until its result is loaded into the output register; the scan ends early
//  on an exact hit, and an empty region skips it. The scan reads through the
//  single read port of the rectangle memory, one rectangle per cycle, and
//  passes each through the read, clamp and compare stages.
//  Reset is synchronous; it clears control state and the region counts.
//  A finished result waits in the output register while the next beat is
//  accepted; a query only stalls at its end if that register is still full.

module nearest_fence_rect_search import nfrs_pkg::*; #(
   parameter int MAX_REGIONS          = 16,
   parameter int MAX_RECTS_PER_REGION = 16
) (
   input  logic         clock,
   input  logic         reset,
   nfrs_req_if.sink     req_bus,
   nfrs_rsp_if.source   rsp_bus
);

   // Region and slot counts are capped at what the 4-bit fields can reach
   localparam int NumRegions = (MAX_REGIONS < (1 << RegionW)) ? MAX_REGIONS : (1 << RegionW);
   localparam int NumSlots   = (MAX_RECTS_PER_REGION < (1 << SlotW)) ?
                               MAX_RECTS_PER_REGION : (1 << SlotW);
   localparam int Depth      = NumRegions * MAX_RECTS_PER_REGION;
   localparam int AddrW      = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW       = $clog2(NumSlots + 1);
   localparam int RegIdxW    = (NumRegions > 1) ? $clog2(NumRegions) : 1;

   typedef struct packed {
      coord_type          q;
      logic [CoordW-1:0]  d;
   } axis_type;

   // Clamp one coordinate into [lo, hi], low bound tested first
   function automatic axis_type clamp_axis(coord_type p, coord_type lo, coord_type hi);
      axis_type          res;
      logic [CoordW:0]   d_lo;
      logic [CoordW:0]   d_hi;
      d_lo = {lo[CoordW-1], lo} - {p[CoordW-1], p};
      d_hi = {p[CoordW-1], p} - {hi[CoordW-1], hi};
      if (p < lo) begin
         res.q = lo;
         res.d = d_lo[CoordW-1:0];
      end else if (p > hi) begin
         res.q = hi;
         res.d = d_hi[CoordW-1:0];
      end else begin
         res.q = p;
         res.d = '0;
      end
      return res;
   endfunction

   state_type          state_ff, state_in;

   rect_type           rect_mem [Depth];
   rect_type           rd_data_ff;

   logic [CntW-1:0]    count_ff [NumRegions];

   logic [RegionW-1:0] region_ff;
   coord_type          px_ff, py_ff;
   logic [CntW-1:0]    qcount_ff;
   logic               empty_ff;
   logic [CntW-1:0]    issue_cnt_ff;

   logic               a_vld_ff;
   logic [CntW-1:0]    a_idx_ff;
   logic               b_vld_ff;
   logic [CntW-1:0]    b_idx_ff;
   axis_type           b_x_ff, b_y_ff;

   logic               found_ff;
   dist_type           best_d_ff;
   coord_type          best_x_ff, best_y_ff;
   logic [CntW-1:0]    best_idx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   coord_type          rsp_x_ff, rsp_y_ff;
   logic [SlotW-1:0]   rsp_rect_ff;
   dist_type           rsp_dist_ff;
   logic               rsp_empty_ff;

   logic               req_accept, region_ok, slot_ok, load_go, query_go;
   logic [CntW-1:0]    req_count;
   logic [31:0]        wr_addr_wide, rd_addr_wide;
   logic [AddrW-1:0]   wr_addr, rd_addr;
   logic               rd_en, scan_end, out_load;
   dist_type           d_sum;
   logic               better, c_zero;
   axis_type           ax_x, ax_y;

   // Request decode
   assign req_accept = req_bus.valid && req_bus.ready;
   assign region_ok  = 32'(req_bus.region_id) < 32'(NumRegions);
   assign slot_ok    = 32'(req_bus.rect_slot) < 32'(NumSlots);
   assign load_go    = req_accept && (req_bus.cmd == CMD_LOAD) && region_ok && slot_ok;
   assign query_go   = req_accept && (req_bus.cmd == CMD_QUERY);
   assign req_count  = region_ok ? count_ff[req_bus.region_id[RegIdxW-1:0]] : '0;

   assign wr_addr_wide = 32'(req_bus.region_id) * 32'(MAX_RECTS_PER_REGION)
                       + 32'(req_bus.rect_slot);
   assign rd_addr_wide = 32'(region_ff) * 32'(MAX_RECTS_PER_REGION) + 32'(issue_cnt_ff);
   assign wr_addr      = wr_addr_wide[AddrW-1:0];
   assign rd_addr      = rd_addr_wide[AddrW-1:0];

   // Compare stage: total distance against the running best
   assign d_sum  = {1'b0, b_x_ff.d} + {1'b0, b_y_ff.d};
   assign better = b_vld_ff && (!found_ff || (d_sum < best_d_ff));
   assign c_zero = better && (d_sum == '0);

   assign scan_end = c_zero ||
                     ((issue_cnt_ff == qcount_ff) && !a_vld_ff && !b_vld_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = (req_count == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_SCAN: rd_en = (issue_cnt_ff < qcount_ff) && !c_zero;
         ST_DONE: out_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Rectangle memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (load_go) begin
         rect_mem[wr_addr] <= '{low_x:  req_bus.rect_low_x,  low_y:  req_bus.rect_low_y,
                                high_x: req_bus.rect_high_x, high_y: req_bus.rect_high_y};
      end
      if (rd_en) begin
         rd_data_ff <= rect_mem[rd_addr];
      end
   end

   // Region counts; a load sets the count to slot + 1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegions; i++) begin
            count_ff[i] <= '0;
         end
      end else if (load_go) begin
         count_ff[req_bus.region_id[RegIdxW-1:0]] <= CntW'(32'(req_bus.rect_slot) + 32'd1);
      end
   end

   // Query context
   always_ff @(posedge clock) begin
      if (query_go) begin
         region_ff <= req_bus.region_id;
         px_ff     <= req_bus.point_x;
         py_ff     <= req_bus.point_y;
         qcount_ff <= req_count;
         empty_ff  <= (req_count == '0);
      end
   end

   // Read issue counter
   always_ff @(posedge clock) begin
      if (reset || query_go) begin
         issue_cnt_ff <= '0;
      end else if (rd_en) begin
         issue_cnt_ff <= issue_cnt_ff + 1'b1;
      end
   end

   // Pipe valids, flushed whenever the scan is not running and when it ends
   always_ff @(posedge clock) begin
      if (reset || (state_ff != ST_SCAN) || scan_end) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= rd_en;
         b_vld_ff <= a_vld_ff;
      end
   end

   // Clamp stage
   assign ax_x = clamp_axis(px_ff, rd_data_ff.low_x, rd_data_ff.high_x);
   assign ax_y = clamp_axis(py_ff, rd_data_ff.low_y, rd_data_ff.high_y);

   always_ff @(posedge clock) begin
      a_idx_ff <= issue_cnt_ff;
      b_idx_ff <= a_idx_ff;
      b_x_ff   <= ax_x;
      b_y_ff   <= ax_y;
   end

   // Running best; first strict minimum wins
   always_ff @(posedge clock) begin
      if (reset || query_go) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_d_ff   <= d_sum;
         best_x_ff   <= b_x_ff.q;
         best_y_ff   <= b_y_ff.q;
         best_idx_ff <= b_idx_ff;
      end
   end

   // Output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (empty_ff) begin
            rsp_x_ff     <= '0;
            rsp_y_ff     <= '0;
            rsp_rect_ff  <= '0;
            rsp_dist_ff  <= '0;
            rsp_empty_ff <= 1'b1;
         end else begin
            rsp_x_ff     <= best_x_ff;
            rsp_y_ff     <= best_y_ff;
            rsp_rect_ff  <= SlotW'(best_idx_ff);
            rsp_dist_ff  <= best_d_ff;
            rsp_empty_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.nearest_x    = rsp_x_ff;
   assign rsp_bus.nearest_y    = rsp_y_ff;
   assign rsp_bus.best_rect    = rsp_rect_ff;
   assign rsp_bus.distance     = rsp_dist_ff;
   assign rsp_bus.empty_region = rsp_empty_ff;

endmodule

`default_nettype wire

// File: src/nfrs_checker.sv
`default_nettype none

module nfrs_checker import nfrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_cmd,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  coord_type          rsp_nearest_x,
   input  coord_type          rsp_nearest_y,
   input  logic [SlotW-1:0]   rsp_best_rect,
   input  dist_type           rsp_distance,
   input  logic               rsp_empty_region
);

   // A stalled response beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_x) &&
         $stable(rsp_nearest_y) && $stable(rsp_best_rect) && $stable(rsp_distance) &&
         $stable(rsp_empty_region))
      else $error("response beat changed while stalled");

   // Empty region result carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_region |-> rsp_nearest_x == '0 && rsp_nearest_y == '0 &&
         rsp_best_rect == '0 && rsp_distance == '0)
      else $error("empty region result with nonzero fields");

   // A query occupies the block: request side closes right after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_QUERY |=> !req_ready)
      else $error("request accepted during a query");

   // A load never produces a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("response after a load");

   // A new response only appears at the end of a query
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a query in progress");

endmodule

bind nearest_fence_rect_search nfrs_checker u_nfrs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_cmd          (req_bus.cmd),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_nearest_x    (rsp_bus.nearest_x),
   .rsp_nearest_y    (rsp_bus.nearest_y),
   .rsp_best_rect    (rsp_bus.best_rect),
   .rsp_distance     (rsp_bus.distance),
   .rsp_empty_region (rsp_bus.empty_region)
);

`default_nettype wire
